// ----- hw/rtl/sfc_pkg.sv -----
// ----------------------------------------------------------------------------
// Stuffed frame codec package
// Shared constants and types for the framer/deframer block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

  localparam int BufDepth = 256;
  localparam int AddrW    = 8;
  localparam int LenW     = 9;

  localparam logic [2:0] OP_RX      = 3'd0;
  localparam logic [2:0] OP_CLEAR   = 3'd1;
  localparam logic [2:0] OP_APP_B   = 3'd2;
  localparam logic [2:0] OP_APP_W   = 3'd3;
  localparam logic [2:0] OP_PULL    = 3'd4;
  localparam logic [2:0] OP_READ_W  = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HDR2 = 3'd1;
  localparam logic [2:0] PH_LENH = 3'd2;
  localparam logic [2:0] PH_LENL = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_CHK  = 3'd5;

  localparam logic [1:0] RX_NONE = 2'd0;
  localparam logic [1:0] RX_BYTE = 2'd1;
  localparam logic [1:0] RX_GOOD = 2'd2;
  localparam logic [1:0] RX_ERR  = 2'd3;

  localparam logic REG_HDR1 = 1'b0;
  localparam logic REG_HDR2 = 1'b1;

  // One decoded item as it travels from the front end to the back end.
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  data_byte;
    logic [15:0] data_word;
    logic [7:0]  word_index;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [8:0]  length_out;
    logic [15:0] word_out;
    logic        overflow;
    logic [1:0]  rx_status;
    logic        line_out_last;
    logic        line_out_valid;
    logic [7:0]  line_out;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sfc_front.sv -----
// ----------------------------------------------------------------------------
// Stuffed frame codec front end
// Accepts items, unpacks them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic [39:0]    s_tdata,
  output logic                q_valid,
  output sfc_pkg::item_t      q_item,
  input  wire logic           q_take
);

  sfc_pkg::item_t slot [2];
  logic [1:0] fill;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       push;
  logic       pop;
  sfc_pkg::item_t in_item;

  // Unpack the input word.
  always_comb begin
    in_item.op         = s_tdata[2:0];
    in_item.data_byte  = s_tdata[10:3];
    in_item.data_word  = s_tdata[26:11];
    in_item.word_index = s_tdata[34:27];
  end

  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_item   = slot[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sfc_back.sv -----
// ----------------------------------------------------------------------------
// Stuffed frame codec back end
// Carries out each item against the buffer memory and the framing state.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [7:0]    cfg_data,
  input  wire logic          q_valid,
  input  wire sfc_pkg::item_t q_item,
  output logic               q_take,
  output logic               res_valid,
  output sfc_pkg::result_t   res,
  input  wire logic          res_ready
);

  localparam logic [1:0] ST_EXEC  = 2'd0;
  localparam logic [1:0] ST_WORD2 = 2'd1;
  localparam logic [1:0] ST_FIN   = 2'd2;
  localparam logic [1:0] ST_APPW  = 2'd3;

  logic [7:0] mem [sfc_pkg::BufDepth];
  logic [7:0] rd_data;
  logic [sfc_pkg::AddrW-1:0] rd_addr;
  logic                      wr_en;
  logic [sfc_pkg::AddrW-1:0] wr_addr;
  logic [7:0]                wr_data;

  logic [7:0] hdr1;
  logic [7:0] hdr2;
  logic [1:0] state;
  logic [1:0] state_next;
  sfc_pkg::item_t cur;

  logic [8:0]  buf_len;
  logic [8:0]  buf_len_next;
  logic [2:0]  rx_phase;
  logic [2:0]  rx_phase_next;
  logic        rx_esc;
  logic        rx_esc_next;
  logic [15:0] rx_decl;
  logic [15:0] rx_decl_next;
  logic [8:0]  rx_count;
  logic [8:0]  rx_count_next;
  logic [7:0]  rx_chk;
  logic [7:0]  rx_chk_next;
  logic [2:0]  tx_phase;
  logic [2:0]  tx_phase_next;
  logic [8:0]  tx_count;
  logic [8:0]  tx_count_next;
  logic [7:0]  tx_chk;
  logic [7:0]  tx_chk_next;
  logic        tx_rep;
  logic        tx_rep_next;
  logic [7:0]  hi_byte;
  logic [7:0]  tx_rd;
  logic [15:0] decl_full;
  logic        res_load;
  sfc_pkg::result_t res_next;

  // Buffer memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr1 <= 8'd170;
      hdr2 <= 8'd85;
    end else if (cfg_we) begin
      if (cfg_index == sfc_pkg::REG_HDR1) hdr1 <= cfg_data;
      else if (cfg_index == sfc_pkg::REG_HDR2) hdr2 <= cfg_data;
    end
  end

  // An item reads memory in EXEC and ends in FIN, or in APPW for a word append.
  // A new item may start in the cycle in which the previous result is taken.
  assign q_take = (state == ST_EXEC) && q_valid && (!res_valid || res_ready);

  assign tx_rd     = (tx_count < 9'(sfc_pkg::BufDepth)) ? rd_data : 8'd0;
  assign decl_full = {rx_decl[15:8], cur.data_byte};

  // Next state of the framing logic, memory access and the result item.
  always_comb begin
    rd_addr       = cur.word_index;
    wr_en         = 1'b0;
    wr_addr       = buf_len[sfc_pkg::AddrW-1:0];
    wr_data       = cur.data_byte;
    state_next    = state;
    buf_len_next  = buf_len;
    rx_phase_next = rx_phase;
    rx_esc_next   = rx_esc;
    rx_decl_next  = rx_decl;
    rx_count_next = rx_count;
    rx_chk_next   = rx_chk;
    tx_phase_next = tx_phase;
    tx_count_next = tx_count;
    tx_chk_next   = tx_chk;
    tx_rep_next   = tx_rep;
    res_next      = '0;
    res_load      = 1'b0;
    case (state)
      ST_EXEC: begin
        rd_addr = (q_item.op == sfc_pkg::OP_READ_W) ? q_item.word_index
                                                    : tx_count[sfc_pkg::AddrW-1:0];
        if (q_take) state_next = (q_item.op == sfc_pkg::OP_READ_W) ? ST_WORD2 : ST_FIN;
      end
      ST_WORD2: begin
        rd_addr    = cur.word_index + 8'd1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        state_next = ST_EXEC;
        res_load   = 1'b1;
        case (cur.op)
          sfc_pkg::OP_RX: begin
            res_next.rx_status = sfc_pkg::RX_BYTE;
            if (rx_phase == sfc_pkg::PH_IDLE) begin
              if (cur.data_byte == hdr1) rx_phase_next = sfc_pkg::PH_HDR2;
              else res_next.rx_status = sfc_pkg::RX_ERR;
            end else if (rx_phase == sfc_pkg::PH_HDR2) begin
              if (cur.data_byte == hdr2) rx_phase_next = sfc_pkg::PH_LENH;
              else begin
                res_next.rx_status = sfc_pkg::RX_ERR;
                rx_phase_next = sfc_pkg::PH_IDLE;
                rx_esc_next = 1'b0;
              end
            end else if (rx_phase > sfc_pkg::PH_CHK ||
                         (rx_esc && cur.data_byte != hdr1)) begin
              res_next.rx_status = sfc_pkg::RX_ERR;
              rx_phase_next = sfc_pkg::PH_IDLE;
              rx_esc_next = 1'b0;
            end else if (!rx_esc && cur.data_byte == hdr1) begin
              rx_esc_next = 1'b1;
            end else begin
              rx_esc_next = 1'b0;
              case (rx_phase)
                sfc_pkg::PH_LENH: begin
                  rx_decl_next  = {cur.data_byte, 8'd0};
                  rx_chk_next   = cur.data_byte;
                  rx_phase_next = sfc_pkg::PH_LENL;
                end
                sfc_pkg::PH_LENL: begin
                  rx_decl_next = decl_full;
                  rx_chk_next  = rx_chk ^ cur.data_byte;
                  if (decl_full > 16'(sfc_pkg::BufDepth)) begin
                    res_next.rx_status = sfc_pkg::RX_ERR;
                    rx_phase_next = sfc_pkg::PH_IDLE;
                  end else begin
                    buf_len_next  = 9'(decl_full);
                    rx_count_next = '0;
                    rx_phase_next = (decl_full != 16'd0) ? sfc_pkg::PH_DATA
                                                         : sfc_pkg::PH_CHK;
                  end
                end
                sfc_pkg::PH_DATA: begin
                  if (rx_count < 9'(sfc_pkg::BufDepth)) begin
                    wr_en   = 1'b1;
                    wr_addr = rx_count[sfc_pkg::AddrW-1:0];
                  end
                  rx_chk_next   = rx_chk ^ cur.data_byte;
                  rx_count_next = rx_count + 9'd1;
                  if (16'(rx_count + 9'd1) >= rx_decl) rx_phase_next = sfc_pkg::PH_CHK;
                end
                default: begin
                  rx_phase_next = sfc_pkg::PH_IDLE;
                  res_next.rx_status = (cur.data_byte == rx_chk) ? sfc_pkg::RX_GOOD
                                                                 : sfc_pkg::RX_ERR;
                end
              endcase
            end
          end
          sfc_pkg::OP_CLEAR: begin
            buf_len_next = '0;
            rx_chk_next  = '0;
          end
          sfc_pkg::OP_APP_B: begin
            if (buf_len < 9'(sfc_pkg::BufDepth)) begin
              wr_en        = 1'b1;
              buf_len_next = buf_len + 9'd1;
            end else begin
              res_next.overflow = 1'b1;
            end
          end
          sfc_pkg::OP_APP_W: begin
            if (10'(buf_len) + 10'd2 > 10'(sfc_pkg::BufDepth)) begin
              res_next.overflow = 1'b1;
            end else begin
              // High byte now, low byte and the result in the next cycle.
              wr_en      = 1'b1;
              wr_data    = cur.data_word[15:8];
              res_load   = 1'b0;
              state_next = ST_APPW;
            end
          end
          sfc_pkg::OP_PULL: begin
            res_next.line_out_valid = 1'b1;
            if (tx_rep) begin
              tx_rep_next = 1'b0;
              res_next.line_out      = hdr1;
              res_next.line_out_last = (tx_phase == sfc_pkg::PH_IDLE);
            end else begin
              case (tx_phase)
                sfc_pkg::PH_IDLE: begin
                  res_next.line_out = hdr1;
                  tx_phase_next = sfc_pkg::PH_HDR2;
                end
                sfc_pkg::PH_HDR2: begin
                  res_next.line_out = hdr2;
                  tx_phase_next = sfc_pkg::PH_LENH;
                end
                sfc_pkg::PH_LENH: begin
                  res_next.line_out = {7'd0, buf_len[8]};
                  tx_chk_next   = {7'd0, buf_len[8]};
                  tx_phase_next = sfc_pkg::PH_LENL;
                end
                sfc_pkg::PH_LENL: begin
                  res_next.line_out = buf_len[7:0];
                  tx_chk_next   = tx_chk ^ buf_len[7:0];
                  tx_count_next = '0;
                  tx_phase_next = (buf_len != 9'd0) ? sfc_pkg::PH_DATA : sfc_pkg::PH_CHK;
                end
                default: begin
                  if (tx_phase == sfc_pkg::PH_DATA && tx_count < buf_len) begin
                    res_next.line_out = tx_rd;
                    tx_chk_next   = tx_chk ^ tx_rd;
                    tx_count_next = tx_count + 9'd1;
                    tx_phase_next = (tx_count + 9'd1 < buf_len) ? sfc_pkg::PH_DATA
                                                                : sfc_pkg::PH_CHK;
                  end else begin
                    res_next.line_out      = tx_chk;
                    tx_phase_next          = sfc_pkg::PH_IDLE;
                    res_next.line_out_last = (tx_chk != hdr1);
                  end
                end
              endcase
              // Bytes after the header that equal the escape value go out twice.
              if (tx_phase != sfc_pkg::PH_IDLE && tx_phase != sfc_pkg::PH_HDR2) begin
                tx_rep_next = (res_next.line_out == hdr1);
              end
            end
          end
          sfc_pkg::OP_READ_W: begin
            res_next.word_out = {hi_byte, (cur.word_index == 8'hFF) ? 8'd0 : rd_data};
          end
          default: ;
        endcase
        res_next.length_out = buf_len_next;
      end
      ST_APPW: begin
        wr_en        = 1'b1;
        wr_addr      = buf_len[sfc_pkg::AddrW-1:0] + 8'd1;
        wr_data      = cur.data_word[7:0];
        buf_len_next = buf_len + 9'd2;
        res_next.length_out = buf_len_next;
        res_load     = 1'b1;
        state_next   = ST_EXEC;
      end
      default: state_next = ST_EXEC;
    endcase
  end

  // Control and framing state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_EXEC;
      res_valid <= 1'b0;
      buf_len   <= '0;
      rx_phase  <= sfc_pkg::PH_IDLE;
      rx_esc    <= 1'b0;
      rx_decl   <= '0;
      rx_count  <= '0;
      rx_chk    <= '0;
      tx_phase  <= sfc_pkg::PH_IDLE;
      tx_count  <= '0;
      tx_chk    <= '0;
      tx_rep    <= 1'b0;
    end else begin
      state    <= state_next;
      buf_len  <= buf_len_next;
      rx_phase <= rx_phase_next;
      rx_esc   <= rx_esc_next;
      rx_decl  <= rx_decl_next;
      rx_count <= rx_count_next;
      rx_chk   <= rx_chk_next;
      tx_phase <= tx_phase_next;
      tx_count <= tx_count_next;
      tx_chk   <= tx_chk_next;
      tx_rep   <= tx_rep_next;
      if (res_load) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  // Item and result data registers.
  always_ff @(posedge clk) begin
    if (q_take) cur <= q_item;
    if (state == ST_WORD2) hi_byte <= rd_data;
    if (res_load) res <= res_next;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/stuffed_frame_codec.sv -----
// ----------------------------------------------------------------------------
// Stuffed frame codec
// Packet buffer with a byte-stuffed framer and deframer.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// s_axis  | in        | tdata: operation, data_byte, data_word, word_index
// m_axis  | out       | tdata: line_out .. length_out
// cfg     | in        | header_first (0), header_second (1)
//
// An item takes EXEC and FIN in the back end (plus WORD2 for a word read,
// APPW for a word append), as the memory has one write and one read port.
// The two-entry queue keeps the input open while a result waits.
// Reset is synchronous and needs no clearing pass.
`default_nettype none

module stuffed_frame_codec (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // operation[2:0], data_byte[10:3], data_word[26:11], word_index[34:27]
  input  wire logic [39:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // line_out[7:0], line_out_valid[8], line_out_last[9], rx_status[11:10],
  // overflow[12], word_out[28:13], length_out[37:29]
  output logic [39:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic q_valid;
  logic q_take;
  sfc_pkg::item_t   q_item;
  sfc_pkg::result_t res;

  sfc_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
  );

  sfc_back u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
    .res_valid(m_tvalid), .res(res), .res_ready(m_tready)
  );

  assign m_tdata = {2'd0, res};

endmodule

`default_nettype wire

// ----- hw/rtl/sfc_checker.sv -----
// ----------------------------------------------------------------------------
// Stuffed frame codec checker
// Port-level properties of the codec, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  // A held result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed");

  // Length never exceeds the buffer size.
  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[37:29] <= 9'(sfc_pkg::BufDepth)) else $error("length");

  // Last only with a valid line byte.
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9] |-> m_tdata[8]) else $error("last without byte");

endmodule

bind stuffed_frame_codec sfc_checker u_chk (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

`default_nettype wire

// ----- bench/tb_stuffed_frame_codec.sv -----
// ----------------------------------------------------------------------------
// Stuffed frame codec testbench
// Drives received line bytes, appends, pulls, word reads and clears through
// the input stream, predicts every result item and checks it field by field.
// ----------------------------------------------------------------------------

// Predicts the block's results and holds the results still to come.
class frame_codec_scoreboard;
  logic [7:0]  hdr1, hdr2;
  logic [7:0]  buf_mem [256];
  logic [8:0]  buf_len;
  logic [2:0]  rx_ph, tx_ph;
  logic        rx_esc, tx_rep;
  logic [15:0] rx_decl;
  logic [8:0]  rx_cnt, tx_cnt;
  logic [7:0]  rx_sum, tx_sum;
  sfc_pkg::result_t pending_results[$];
  int mismatches;

  function new();
    hdr1 = 8'd170;
    hdr2 = 8'd85;
    buf_len = '0;
    rx_ph = sfc_pkg::PH_IDLE;
    tx_ph = sfc_pkg::PH_IDLE;
    rx_esc = 0;
    tx_rep = 0;
    rx_decl = '0;
    rx_cnt = '0;
    tx_cnt = '0;
    rx_sum = '0;
    tx_sum = '0;
    mismatches = 0;
    foreach (buf_mem[i]) buf_mem[i] = 8'h00;
  endfunction

  function logic [7:0] byte_at(int pos);
    return (pos < 256) ? buf_mem[pos] : 8'h00;
  endfunction

  function logic [1:0] deframe(logic [7:0] b);
    if (rx_ph == sfc_pkg::PH_IDLE) begin
      if (b == hdr1) begin
        rx_ph = sfc_pkg::PH_HDR2;
        return sfc_pkg::RX_BYTE;
      end
      return sfc_pkg::RX_ERR;
    end
    if (rx_ph == sfc_pkg::PH_HDR2) begin
      if (b != hdr2) begin
        rx_ph = sfc_pkg::PH_IDLE;
        return sfc_pkg::RX_ERR;
      end
      rx_ph = sfc_pkg::PH_LENH;
      return sfc_pkg::RX_BYTE;
    end
    // Escape handling: a doubled first-header value stands for one byte.
    if (rx_esc) begin
      rx_esc = 0;
      if (b != hdr1) begin
        rx_ph = sfc_pkg::PH_IDLE;
        return sfc_pkg::RX_ERR;
      end
    end else if (b == hdr1) begin
      rx_esc = 1;
      return sfc_pkg::RX_BYTE;
    end
    case (rx_ph)
      sfc_pkg::PH_LENH: begin
        rx_decl = {b, 8'h00};
        rx_sum = b;
        rx_ph = sfc_pkg::PH_LENL;
        return sfc_pkg::RX_BYTE;
      end
      sfc_pkg::PH_LENL: begin
        rx_decl[7:0] = b;
        rx_sum ^= b;
        if (rx_decl > 16'd256) begin
          rx_ph = sfc_pkg::PH_IDLE;
          return sfc_pkg::RX_ERR;
        end
        buf_len = rx_decl[8:0];
        rx_cnt = '0;
        rx_ph = (rx_decl != 0) ? sfc_pkg::PH_DATA : sfc_pkg::PH_CHK;
        return sfc_pkg::RX_BYTE;
      end
      sfc_pkg::PH_DATA: begin
        if (rx_cnt < 256) buf_mem[rx_cnt[7:0]] = b;
        rx_sum ^= b;
        rx_cnt++;
        if (rx_cnt >= rx_decl) rx_ph = sfc_pkg::PH_CHK;
        return sfc_pkg::RX_BYTE;
      end
      default: begin
        rx_ph = sfc_pkg::PH_IDLE;
        return (b == rx_sum) ? sfc_pkg::RX_GOOD : sfc_pkg::RX_ERR;
      end
    endcase
  endfunction

  function logic [7:0] frame_next(output logic fin);
    logic [7:0] v;
    fin = 0;
    if (tx_rep) begin
      tx_rep = 0;
      fin = (tx_ph == sfc_pkg::PH_IDLE);
      return hdr1;
    end
    case (tx_ph)
      sfc_pkg::PH_IDLE: begin
        tx_ph = sfc_pkg::PH_HDR2;
        return hdr1;
      end
      sfc_pkg::PH_HDR2: begin
        tx_ph = sfc_pkg::PH_LENH;
        return hdr2;
      end
      sfc_pkg::PH_LENH: begin
        v = {7'd0, buf_len[8]};
        tx_sum = v;
        tx_ph = sfc_pkg::PH_LENL;
      end
      sfc_pkg::PH_LENL: begin
        v = buf_len[7:0];
        tx_sum ^= v;
        tx_cnt = '0;
        tx_ph = (buf_len != 0) ? sfc_pkg::PH_DATA : sfc_pkg::PH_CHK;
      end
      default: begin
        if (tx_ph == sfc_pkg::PH_DATA && tx_cnt < buf_len) begin
          v = byte_at(tx_cnt);
          tx_sum ^= v;
          tx_cnt++;
          tx_ph = (tx_cnt < buf_len) ? sfc_pkg::PH_DATA : sfc_pkg::PH_CHK;
        end else begin
          v = tx_sum;
          tx_ph = sfc_pkg::PH_IDLE;
          fin = (v != hdr1);
        end
      end
    endcase
    if (v == hdr1) tx_rep = 1;
    return v;
  endfunction

  function void set_register(logic idx, logic [7:0] val);
    if (idx == sfc_pkg::REG_HDR1) hdr1 = val;
    else hdr2 = val;
  endfunction

  // Notes an accepted input item and queues the result it causes.
  function void note_item(sfc_pkg::item_t it);
    sfc_pkg::result_t r;
    logic fin;
    r = '0;
    case (it.op)
      sfc_pkg::OP_RX: r.rx_status = deframe(it.data_byte);
      sfc_pkg::OP_CLEAR: begin
        buf_len = '0;
        rx_sum = '0;
      end
      sfc_pkg::OP_APP_B: begin
        if (buf_len + 1 > 256) r.overflow = 1;
        else begin
          buf_mem[buf_len[7:0]] = it.data_byte;
          buf_len++;
        end
      end
      sfc_pkg::OP_APP_W: begin
        if (buf_len + 2 > 256) r.overflow = 1;
        else begin
          buf_mem[buf_len[7:0]] = it.data_word[15:8];
          buf_mem[buf_len[7:0] + 8'd1] = it.data_word[7:0];
          buf_len += 2;
        end
      end
      sfc_pkg::OP_PULL: begin
        r.line_out = frame_next(fin);
        r.line_out_valid = 1;
        r.line_out_last = fin;
      end
      sfc_pkg::OP_READ_W:
        r.word_out = {byte_at(it.word_index), byte_at(int'(it.word_index) + 1)};
      default: ;
    endcase
    r.length_out = buf_len;
    pending_results.push_back(r);
  endfunction

  // Checks one result item against the oldest expectation.
  function void check_result(sfc_pkg::result_t got);
    sfc_pkg::result_t exp_r;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item %h", got);
      return;
    end
    exp_r = pending_results.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result mismatch: line %h/%b/%b st %0d ovf %b word %h len %0d",
                 got.line_out, got.line_out_valid, got.line_out_last, got.rx_status,
                 got.overflow, got.word_out, got.length_out);
        $display("  expected line %h/%b/%b st %0d ovf %b word %h len %0d",
                 exp_r.line_out, exp_r.line_out_valid, exp_r.line_out_last,
                 exp_r.rx_status, exp_r.overflow, exp_r.word_out, exp_r.length_out);
      end
    end
  endfunction
endclass

module tb_stuffed_frame_codec;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [7:0]  cfg_data = '0;

  frame_codec_scoreboard board = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit hold_receiver = 0;
  int quiet_cycles = 0;
  // Bytes the model holds as written; reads stay below this mark.
  int written_mark = 0;

  stuffed_frame_codec dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Result side: random stalls, an optional long hold, and the check.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata[37:0]);
    m_tready <= !hold_receiver && ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog on cycles with no accepted item.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("tb_stuffed_frame_codec NOT OK");
      $finish;
    end
  end

  // Offers one item and waits until it is accepted. The valid stays high
  // afterwards so that the next item can follow with no gap.
  task automatic send_item(logic [2:0] op, logic [7:0] b = 0, logic [15:0] w = 0,
                           logic [7:0] idx = 0);
    sfc_pkg::item_t it;
    it = '{op: op, data_byte: b, data_word: w, word_index: idx};
    // A pause first withdraws the previous item so that it is not taken twice.
    if ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 0;
      do @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct);
    end
    s_tvalid <= 1;
    s_tdata <= {5'd0, idx, w, b, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_item(it);
  endtask

  task automatic wait_drained();
    s_tvalid <= 0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [7:0] val);
    wait_drained();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    board.set_register(idx, val);
  endtask

  // Sends a line byte, doubled where it equals the escape value.
  task automatic send_stuffed(logic [7:0] b);
    send_item(sfc_pkg::OP_RX, b);
    if (b == board.hdr1) send_item(sfc_pkg::OP_RX, b);
  endtask

  // Sends a received frame; broken frames corrupt one part of it.
  task automatic send_frame(int len, int fault);
    logic [7:0] sum, b;
    sum = len[15:8] ^ len[7:0];
    send_item(sfc_pkg::OP_RX, fault == 1 ? ~board.hdr1 : board.hdr1);
    if (fault == 1) return;
    send_item(sfc_pkg::OP_RX, fault == 2 ? ~board.hdr2 : board.hdr2);
    if (fault == 2) return;
    send_stuffed(len[15:8]);
    send_stuffed(len[7:0]);
    if (len > 256) return;
    for (int i = 0; i < len; i++) begin
      b = ($urandom_range(3) == 0) ? board.hdr1 : 8'($urandom);
      if (fault == 3 && i == len / 2) begin
        send_item(sfc_pkg::OP_RX, board.hdr1);
        send_item(sfc_pkg::OP_RX, board.hdr1 ^ 8'h01);
        return;
      end
      sum ^= b;
      send_stuffed(b);
    end
    send_stuffed(fault == 4 ? ~sum : sum);
    if (fault == 0 && board.rx_ph == sfc_pkg::PH_IDLE) written_mark = len;
  endtask

  task automatic pull_frame();
    do send_item(sfc_pkg::OP_PULL);
    while (!(board.pending_results[$].line_out_last));
  endtask

  task automatic random_item();
    int k;
    k = $urandom_range(99);
    if (k < 30) begin
      if (board.buf_len < 250 && board.buf_len == written_mark) begin
        send_item(sfc_pkg::OP_APP_B, 8'($urandom));
        written_mark = board.buf_len;
      end else send_item(sfc_pkg::OP_RX, 8'($urandom));
    end else if (k < 40) begin
      if (board.buf_len < 250 && board.buf_len == written_mark) begin
        send_item(sfc_pkg::OP_APP_W, 0, 16'($urandom));
        written_mark = board.buf_len;
      end else send_item(sfc_pkg::OP_CLEAR);
    end else if (k < 55 && written_mark >= 2) begin
      send_item(sfc_pkg::OP_READ_W, 0, 0, 8'($urandom_range(written_mark - 2)));
    end else if (k < 62) begin
      send_item(3'($urandom_range(7, 6)), 8'($urandom), 16'($urandom), 8'($urandom));
    end else if (k < 70) begin
      send_item(sfc_pkg::OP_CLEAR);
      written_mark = 0;
    end else if (k < 85) begin
      send_frame($urandom_range(12), $urandom_range(9) < 7 ? 0 : $urandom_range(4, 1));
    end else if (board.buf_len <= written_mark) begin
      pull_frame();
    end
  endtask

  task automatic run_phase(int n, int idle, int stall);
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    for (int i = 0; i < n; i++) random_item();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: clears, appends to the buffer edge, overflow, reads, frames.
    send_item(sfc_pkg::OP_CLEAR);
    send_item(sfc_pkg::OP_APP_W, 0, 16'hFFFF);
    send_item(sfc_pkg::OP_APP_B, 8'h00);
    send_item(sfc_pkg::OP_APP_B, 8'hFF);
    send_item(sfc_pkg::OP_READ_W, 0, 0, 8'd0);
    send_item(sfc_pkg::OP_READ_W, 0, 0, 8'd2);
    for (int i = 0; i < 126; i++) send_item(sfc_pkg::OP_APP_W, 0, 16'($urandom));
    send_item(sfc_pkg::OP_APP_B, 8'h5A);
    send_item(sfc_pkg::OP_APP_B, 8'hA5);
    send_item(sfc_pkg::OP_APP_B, 8'h11);
    send_item(sfc_pkg::OP_APP_W, 0, 16'h1234);
    send_item(sfc_pkg::OP_READ_W, 0, 0, 8'd254);
    written_mark = 256;
    // Transmit of a full buffer, whose length high byte is one.
    pull_frame();
    // A zero length frame, two oversized lengths and each error case.
    send_frame(0, 0);
    written_mark = 0;
    send_frame(257, 0);
    send_frame(16'hFFFF, 0);
    for (int f = 1; f <= 4; f++) send_frame(3, f);
    send_item(sfc_pkg::OP_SPARE_6, 8'hFF, 16'hFFFF, 8'hFF);
    send_item(sfc_pkg::OP_SPARE_7);

    // Random phases over several header settings.
    run_phase(8, 0, 0);
    write_register(sfc_pkg::REG_HDR1, 8'h00);
    write_register(sfc_pkg::REG_HDR2, 8'hFF);
    run_phase(8, 74, 0);
    write_register(sfc_pkg::REG_HDR1, 8'hFF);
    write_register(sfc_pkg::REG_HDR2, 8'h00);
    run_phase(8, 0, 74);
    write_register(sfc_pkg::REG_HDR1, 8'h7E);
    write_register(sfc_pkg::REG_HDR2, 8'h7E);
    run_phase(8, 7, 7);

    // Long receiver hold while items keep coming, then a full drain.
    hold_receiver = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_receiver = 0;
      end
      for (int i = 0; i < 12; i++) send_item(sfc_pkg::OP_CLEAR);
    join
    written_mark = 0;
    wait_drained();
    write_register(sfc_pkg::REG_HDR1, 8'd170);
    write_register(sfc_pkg::REG_HDR2, 8'd85);
    run_phase(8, 7, 7);

    wait_drained();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending_results.size() == 0)
      $display("tb_stuffed_frame_codec OK");
    else
      $display("tb_stuffed_frame_codec NOT OK");
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/sfc_pkg.sv
hw/rtl/sfc_front.sv
hw/rtl/sfc_back.sv
hw/rtl/stuffed_frame_codec.sv
hw/rtl/sfc_checker.sv
bench/tb_stuffed_frame_codec.sv
